>>> design/rtc_calendar_counter_macros.svh
// Assertion macros shared by the real-time clock calendar RTL.
`ifndef RTC_CALENDAR_COUNTER_MACROS_SVH
`define RTC_CALENDAR_COUNTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RTCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RTCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcc assertion failed");
`else
`define RTCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RTCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/rtcc_pkg.sv
// Types, constants and calendar functions of the real-time clock calendar.
`default_nettype none
package rtcc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_TIME = 2'd1,
        CMD_SET_DATE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_MONTH    = 2'd1,
        STATUS_BAD_DAY_YEAR = 2'd2
    } status_t;

    typedef struct packed {
        command_t    command;
        logic [6:0]  new_hour;
        logic [6:0]  new_minute;
        logic [6:0]  new_second;
        logic        is_pm;
        logic [6:0]  new_day;
        logic [6:0]  entry_month;
        logic [13:0] entry_year;
    } item_t;

    typedef struct packed {
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic [4:0]  shown_hour;
        logic        pm_flag;
        logic        second_pulse;
        logic        top_of_hour;
        status_t     status;
    } result_t;

    localparam logic [5:0]  SECOND_LAST   = 6'd59;
    localparam logic [5:0]  MINUTE_LAST   = 6'd59;
    localparam logic [4:0]  HOUR_LAST     = 5'd23;
    localparam logic [4:0]  HOUR_NOON     = 5'd12;
    localparam logic [3:0]  MONTH_LAST    = 4'd12;
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [13:0] YEAR_SET_MIN  = 14'd2000;
    localparam logic [13:0] YEAR_SET_MAX  = 14'd2099;

    // Multiplicative inverse of 25 modulo 2**14 and the largest quotient of a
    // multiple of 25 below 2**14; a product at or under the limit marks a multiple.
    localparam logic [13:0] INV25_MOD14   = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT   = 14'd655;

    // Gregorian leap rule. Divisible by 400 is divisible by 16 and by 25;
    // divisible by 100 is divisible by 4 and by 25.
    function automatic logic is_leap(input logic [13:0] year);
        logic [13:0] prod;
        logic        div25;
        prod  = year * INV25_MOD14;
        div25 = (prod <= DIV25_LIMIT);
        return div25 ? (year[3:0] == 4'd0) : (year[1:0] == 2'd0);
    endfunction

    // Length of a month; months outside 1..12 count as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month) inside
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage
`default_nettype wire

>>> design/rtcc_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none
interface rtcc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/rtc_calendar_counter.sv
// Real-time clock with Gregorian calendar: command decode, counters and result buffer.
`default_nettype none
// Usage:
// The item channel takes one command per transaction: a 10 ms tick, a set-time or a
// set-date. Every accepted command produces exactly one transaction on the result
// channel, showing the time and date after the command, the display hour, pm flag,
// second pulse, top-of-hour flag and the set-date status.
// The cfg channel writes the twelve-hour mode bit; it is always ready and should be
// written only while no result is outstanding.
// An accepted command's result is registered in the result register, or in the skid
// register while a result waits. Throughput is one command per cycle while item.ready
// is high, set by the single pass of counter update logic between the state registers
// and the result register. A two-entry output buffer (result register plus skid register)
// keeps the item channel open while one result waits; item.ready drops only when both
// entries hold results, and rises again as soon as the receiver takes one.
// Reset clears the time to 00:00:00, leaves the date unset (all zero), selects
// twelve-hour mode and empties the output buffer. There is no clearing pass.
// The date advances at midnight only while day, month and year are all nonzero,
// and the year saturates at 9999.
`include "rtc_calendar_counter_macros.svh"
module rtc_calendar_counter
    import rtcc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100
) (
    input  wire           clk,
    input  wire           rst_n,
    rtcc_stream_if.sink   item,
    rtcc_stream_if.source result,
    rtcc_stream_if.sink   cfg
);

    // The sub-second counter only needs to hold 0 .. TICKS_PER_SECOND-1.
    localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    // Time and date state.
    logic [TICK_W-1:0] tick_reg,   tick_next;
    logic [5:0]        second_reg, second_next;
    logic [5:0]        minute_reg, minute_next;
    logic [4:0]        hour_reg,   hour_next;
    logic [4:0]        day_reg,    day_next;
    logic [3:0]        month_reg,  month_next;
    logic [13:0]       year_reg,   year_next;
    logic              twelve_reg;

    // Output buffer.
    logic              out_valid_reg;
    logic              skid_valid_reg;
    result_t           out_data_reg;
    result_t           skid_data_reg;

    logic              item_accept;
    logic              result_take;
    result_t           res_new;

    // Cascade terms for a tick.
    logic              tick_wrap;
    logic              second_wrap;
    logic              minute_wrap;
    logic              hour_wrap;
    logic              date_set;
    logic [5:0]        day_plus;
    logic              month_end;

    // Set-time and set-date terms.
    logic [7:0]        hour_conv;
    logic [4:0]        set_month_len;
    logic              pulse;
    status_t           status;

    assign item.ready   = !skid_valid_reg;
    assign cfg.ready    = 1'b1;
    assign item_accept  = item.valid && item.ready;
    assign result_take  = out_valid_reg && result.ready;
    assign result.valid = out_valid_reg;
    assign result.payload = out_data_reg;

    // Hour, minute and second never exceed their last value, so the wrap test is
    // a compare against that value.
    assign tick_wrap   = (tick_reg == TICK_LAST);
    assign second_wrap = tick_wrap && (second_reg >= SECOND_LAST);
    assign minute_wrap = second_wrap && (minute_reg >= MINUTE_LAST);
    assign hour_wrap   = minute_wrap && (hour_reg >= HOUR_LAST);
    assign date_set    = (day_reg != 5'd0) && (month_reg != 4'd0) && (year_reg != 14'd0);
    assign day_plus    = {1'b0, day_reg} + 6'd1;
    assign month_end   = day_plus > {1'b0, month_days(month_reg, is_leap(year_reg))};

    assign set_month_len = month_days(item.payload.entry_month[3:0],
                                      is_leap(item.payload.entry_year));

    always_comb
    begin
        hour_conv = {1'b0, item.payload.new_hour};
        if (twelve_reg)
        begin
            if (item.payload.new_hour == {2'b0, HOUR_NOON})
            begin
                hour_conv = item.payload.is_pm ? {3'b0, HOUR_NOON} : 8'd0;
            end
            else if (item.payload.is_pm)
            begin
                hour_conv = {1'b0, item.payload.new_hour} + {3'b0, HOUR_NOON};
            end
        end
    end

    always_comb
    begin
        tick_next   = tick_reg;
        second_next = second_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        pulse       = 1'b0;
        status      = STATUS_OK;

        unique case (item.payload.command)
            CMD_TICK:
            begin
                tick_next = tick_wrap ? '0 : tick_reg + TICK_W'(1);
                pulse     = tick_wrap;
                if (tick_wrap)
                begin
                    second_next = second_wrap ? 6'd0 : second_reg + 6'd1;
                end
                if (second_wrap)
                begin
                    minute_next = minute_wrap ? 6'd0 : minute_reg + 6'd1;
                end
                if (minute_wrap)
                begin
                    hour_next = hour_wrap ? 5'd0 : hour_reg + 5'd1;
                end
                if (hour_wrap && date_set)
                begin
                    if (month_end)
                    begin
                        day_next = 5'd1;
                        if (month_reg >= MONTH_LAST)
                        begin
                            month_next = 4'd1;
                            if (year_reg < YEAR_MAX)
                            begin
                                year_next = year_reg + 14'd1;
                            end
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        day_next = day_plus[4:0];
                    end
                end
            end
            CMD_SET_TIME:
            begin
                hour_next   = (hour_conv > {3'b0, HOUR_LAST}) ? HOUR_LAST : hour_conv[4:0];
                minute_next = (item.payload.new_minute > {1'b0, MINUTE_LAST}) ?
                              MINUTE_LAST : item.payload.new_minute[5:0];
                second_next = (item.payload.new_second > {1'b0, SECOND_LAST}) ?
                              SECOND_LAST : item.payload.new_second[5:0];
                tick_next   = '0;
            end
            CMD_SET_DATE:
            begin
                if ((item.payload.entry_month == 7'd0) ||
                    (item.payload.entry_month > {3'b0, MONTH_LAST}))
                begin
                    status = STATUS_BAD_MONTH;
                end
                else if ((item.payload.new_day == 7'd0) ||
                         (item.payload.new_day > {2'b0, set_month_len}) ||
                         (item.payload.entry_year < YEAR_SET_MIN) ||
                         (item.payload.entry_year > YEAR_SET_MAX))
                begin
                    status = STATUS_BAD_DAY_YEAR;
                end
                else
                begin
                    day_next   = item.payload.new_day[4:0];
                    month_next = item.payload.entry_month[3:0];
                    year_next  = item.payload.entry_year;
                end
            end
            default:
            begin
                // The unused command code leaves the state alone.
            end
        endcase
    end

    // Result fields are taken from the state as it stands after this command.
    always_comb
    begin
        res_new.cur_hour     = hour_next;
        res_new.cur_minute   = minute_next;
        res_new.cur_second   = second_next;
        res_new.cur_day      = day_next;
        res_new.cur_month    = month_next;
        res_new.cur_year     = year_next;
        res_new.shown_hour   = hour_next;
        res_new.pm_flag      = 1'b0;
        if (twelve_reg)
        begin
            if (hour_next == 5'd0)
            begin
                res_new.shown_hour = HOUR_NOON;
            end
            else if (hour_next > HOUR_NOON)
            begin
                res_new.shown_hour = hour_next - HOUR_NOON;
            end
            res_new.pm_flag = (hour_next >= HOUR_NOON);
        end
        res_new.second_pulse = pulse;
        res_new.top_of_hour  = (minute_next == 6'd0) && (second_next < 6'd3);
        res_new.status       = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            second_reg <= 6'd0;
            minute_reg <= 6'd0;
            hour_reg   <= 5'd0;
            day_reg    <= 5'd0;
            month_reg  <= 4'd0;
            year_reg   <= 14'd0;
            twelve_reg <= 1'b1;
        end
        else
        begin
            if (item_accept)
            begin
                tick_reg   <= tick_next;
                second_reg <= second_next;
                minute_reg <= minute_next;
                hour_reg   <= hour_next;
                day_reg    <= day_next;
                month_reg  <= month_next;
                year_reg   <= year_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                twelve_reg <= cfg.payload;
            end
        end
    end

    // Output buffer control. A new result goes to the result register when it is
    // free or being taken, and to the skid register otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_take)
            begin
                out_valid_reg  <= skid_valid_reg || item_accept;
                skid_valid_reg <= 1'b0;
            end
            else if (item_accept)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_new;
        end
        else if (item_accept)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= res_new;
            end
            else
            begin
                out_data_reg <= res_new;
            end
        end
    end

    // The skid register only fills behind a waiting result.
    `RTCC_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // Day, month and year are set and cleared together.
    `RTCC_ASSERT_IMPL(a_date_all_or_none, clk, rst_n, 1'b1,
        ((day_reg == 5'd0) == (month_reg == 4'd0)) && ((month_reg == 4'd0) == (year_reg == 14'd0)))
    // Time counters stay within their ranges.
    `RTCC_ASSERT_IMPL(a_time_in_range, clk, rst_n, 1'b1,
        (hour_reg <= HOUR_LAST) && (minute_reg <= MINUTE_LAST) && (second_reg <= SECOND_LAST))
    // A tick on the last sub-second count wraps the counter and shows a pulse.
    `RTCC_ASSERT_NEXT(a_tick_wrap_pulse, clk, rst_n,
        item_accept && (item.payload.command == CMD_TICK) && tick_wrap && !out_valid_reg,
        (tick_reg == '0) && out_valid_reg && out_data_reg.second_pulse)

endmodule
`default_nettype wire
